// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL files.
// Define ASSERT_OFF to compile the design without its assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// The expression holds at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed: invariant violated");
// When the antecedent holds, the consequent holds at the next clock edge.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle check violated");
`else
`define ASSERT_HOLDS(lbl, clk, rst_n, expr)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/hlcd_pkg.sv =====
`default_nettype none

package hlcd_pkg;

	// Fixed field widths.
	localparam int KIND_W     = 2;
	localparam int ENC_W      = 12;
	localparam int LPC_W      = 20;
	localparam int THR_W      = 16;
	localparam int OUT_CNT_W  = 32;
	localparam int DEPTH_W    = 48;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 20;

	// Encoder fold: quotient estimate by reciprocal multiplication.
	localparam int MOD_SHIFT = 24;
	localparam int QEST_W    = 6;

	// Item kinds; every other code is an encoder sample only.
	localparam logic [KIND_W-1:0] KIND_EDGE_A = 2'd0;
	localparam logic [KIND_W-1:0] KIND_EDGE_B = 2'd1;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_LINE_PER_COUNT  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_THRESHOLD = 4'd1;

	localparam logic [LPC_W-1:0] LPC_RESET = 20'd9858;
	localparam logic [THR_W-1:0] THR_RESET = 16'd10;

	// Cosine table generation in Q30.
	localparam logic [63:0] Q30_ONE    = 64'd1 << 30;
	localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
	localparam logic [63:0] COS_DIV [8] = '{64'd2, 64'd12, 64'd30, 64'd56,
		64'd90, 64'd132, 64'd182, 64'd240};

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_WAIT_B,
		PH_WAIT_A
	} phase_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MOD,
		S_FOLD,
		S_ROM,
		S_MULT,
		S_SUM,
		S_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic modulo;
		logic fold;
		logic rom;
		logic mult;
		logic sum;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic in_range;
	} dp_status_t;

endpackage

`default_nettype wire

// ===== src/hlcd_if.sv =====
`default_nettype none

// Sensor and encoder events.
interface hlcd_hall_if import hlcd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic              hall_a;
	logic              hall_b;
	logic [ENC_W-1:0]  encoder_count;

	modport source (output valid, kind, hall_a, hall_b, encoder_count, input ready);
	modport sink (input valid, kind, hall_a, hall_b, encoder_count, output ready);
endinterface

// Counter and depth results.
interface hlcd_result_if import hlcd_pkg::*; ();
	logic                        valid;
	logic                        ready;
	logic [OUT_CNT_W-1:0]        cw_passes;
	logic [OUT_CNT_W-1:0]        ccw_passes;
	logic [OUT_CNT_W-1:0]        all_passes;
	logic signed [OUT_CNT_W-1:0] net_passes;
	logic [DEPTH_W-1:0]          depth_q16;
	logic                        drive_on;

	modport source (output valid, cw_passes, ccw_passes, all_passes, net_passes,
		depth_q16, drive_on, input ready);
	modport sink (input valid, cw_passes, ccw_passes, all_passes, net_passes,
		depth_q16, drive_on, output ready);
endinterface

// Register writes.
interface hlcd_cfg_if import hlcd_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/hlcd_ctrl.sv =====
`default_nettype none
`include "assert_macros.svh"

module hlcd_ctrl import hlcd_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  wire logic       out_ready,
	input  wire dp_status_t status,
	output dp_cmd_t         cmd
);

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_nxt = S_MOD;
				end
			end
			S_MOD:  state_nxt = S_FOLD;
			S_FOLD: state_nxt = S_ROM;
			S_ROM: begin
				// Above ninety degrees the held depth stands; skip the multiply.
				state_nxt = status.in_range ? S_MULT : S_DONE;
			end
			S_MULT: state_nxt = S_SUM;
			S_SUM:  state_nxt = S_DONE;
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			S_MOD:  cmd.modulo = 1'b1;
			S_FOLD: cmd.fold = 1'b1;
			S_ROM:  cmd.rom = 1'b1;
			S_MULT: cmd.mult = 1'b1;
			S_SUM:  cmd.sum = 1'b1;
			S_DONE: cmd.finish = !out_valid_q || out_ready;
			default: begin
				cmd      = '0;
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`ASSERT_NEXT(a_accept_starts_work, clk, arst_n, in_valid && in_ready, state_q == S_MOD)
	`ASSERT_NEXT(a_done_waits_for_sink, clk, arst_n,
		state_q == S_DONE && out_valid_q && !out_ready, state_q == S_DONE && out_valid_q)

endmodule

`default_nettype wire

// ===== src/hlcd_datapath.sv =====
`default_nettype none
`include "assert_macros.svh"

module hlcd_datapath import hlcd_pkg::*; #(
	parameter int ENCODER_COUNTS = 2048,
	parameter int COUNT_WIDTH    = 32,
	parameter int COS_FRAC_BITS  = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire dp_cmd_t               cmd,
	output dp_status_t                 status,
	input  wire logic [KIND_W-1:0]     kind,
	input  wire logic                  hall_a,
	input  wire logic                  hall_b,
	input  wire logic [ENC_W-1:0]      encoder_count,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output logic [OUT_CNT_W-1:0]       cw_passes,
	output logic [OUT_CNT_W-1:0]       ccw_passes,
	output logic [OUT_CNT_W-1:0]       all_passes,
	output logic signed [OUT_CNT_W-1:0] net_passes,
	output logic [DEPTH_W-1:0]         depth_q16,
	output logic                       drive_on
);

	localparam int unsigned RECIP = (1 << MOD_SHIFT) / ENCODER_COUNTS;
	localparam int QUARTER   = ENCODER_COUNTS / 4;
	localparam int ENC_LAST  = (1 << ENC_W) - 1;
	localparam int ROM_LAST  = (QUARTER < ENC_LAST) ? QUARTER : ENC_LAST;
	localparam int ROM_DEPTH = ROM_LAST + 1;
	localparam int IDX_W     = $clog2(ROM_DEPTH);
	localparam int COS_W     = COS_FRAC_BITS + 1;
	localparam int LINE_W    = COUNT_WIDTH + LPC_W;
	localparam int LO_W      = (LINE_W + 1) / 2;
	localparam int HI_W      = LINE_W - LO_W;
	localparam int PP_LO_W   = LO_W + COS_W;
	localparam int PP_HI_W   = HI_W + COS_W;
	localparam int PROD_W    = LINE_W + COS_W;
	localparam int SH_W      = PROD_W - COS_FRAC_BITS;
	localparam int SHX_W     = (SH_W > DEPTH_W) ? SH_W : DEPTH_W;

	// Cosine of the folded count in Q(COS_FRAC_BITS), from a Q30 series.
	function automatic logic [COS_W-1:0] cos_entry(input int unsigned p);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] q;
		x = (64'(p) * TWO_PI_Q30 + 64'(ENCODER_COUNTS / 2)) / ENCODER_COUNTS;
		x2 = (x * x) >> 30;
		t = Q30_ONE;
		for (int k = 8; k >= 1; k--) begin
			q = ((x2 * t) >> 30) / COS_DIV[k-1];
			t = (q >= Q30_ONE) ? 64'd0 : Q30_ONE - q;
		end
		return COS_W'((t + (64'd1 << (29 - COS_FRAC_BITS))) >> (30 - COS_FRAC_BITS));
	endfunction

	logic [COS_W-1:0] cos_rom [ROM_DEPTH];

	for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_cos_rom
		assign cos_rom[g] = cos_entry(g);
	end

	// Configuration and counting state.
	logic [LPC_W-1:0]       lpc_q;
	logic [THR_W-1:0]       thr_q;
	phase_t                 phase_q;
	phase_t                 phase_nxt;
	logic [COUNT_WIDTH-1:0] cw_q;
	logic [COUNT_WIDTH-1:0] ccw_q;
	logic [COUNT_WIDTH-1:0] total_q;
	logic [DEPTH_W-1:0]     held_q;
	logic                   inc_cw;
	logic                   inc_ccw;

	// Work registers of one item.
	logic [ENC_W-1:0]       enc_q;
	logic [QEST_W-1:0]      q_est_q;
	logic [ENC_W-1:0]       rem_q;
	logic [COUNT_WIDTH-1:0] mag_q;
	logic [LINE_W-1:0]      line_q;
	logic [ENC_W-1:0]       p_q;
	logic                   in_range_q;
	logic [COS_W-1:0]       cos_q;
	logic [PP_LO_W-1:0]     pp_lo_q;
	logic [PP_HI_W-1:0]     pp_hi_q;
	logic [DEPTH_W-1:0]     depth_calc_q;

	logic [COUNT_WIDTH-1:0] net;
	logic [ENC_W-1:0]       r_mod;
	logic [ENC_W-1:0]       p_fold;
	logic                   p_ok;
	logic [PROD_W-1:0]      prod;
	logic [SHX_W-1:0]       prod_sh;
	logic [DEPTH_W-1:0]     depth_new;

	always_comb begin
		phase_nxt = phase_q;
		inc_cw    = 1'b0;
		inc_ccw   = 1'b0;
		case (kind)
			KIND_EDGE_A: begin
				if (!hall_a) begin
					if (phase_q == PH_IDLE) begin
						phase_nxt = PH_WAIT_B;
					end else if (phase_q == PH_WAIT_A) begin
						inc_ccw   = 1'b1;
						phase_nxt = PH_IDLE;
					end
				end else if (phase_q == PH_WAIT_B && hall_b) begin
					phase_nxt = PH_IDLE;
				end
			end
			KIND_EDGE_B: begin
				if (!hall_b) begin
					if (phase_q == PH_IDLE) begin
						phase_nxt = PH_WAIT_A;
					end else if (phase_q == PH_WAIT_B) begin
						inc_cw    = 1'b1;
						phase_nxt = PH_IDLE;
					end
				end else if (phase_q == PH_WAIT_A && hall_a) begin
					phase_nxt = PH_IDLE;
				end
			end
			default: phase_nxt = phase_q;
		endcase
	end

	assign net = cw_q - ccw_q;

	always_comb begin
		r_mod = (32'(rem_q) >= 32'(ENCODER_COUNTS))
			? ENC_W'(32'(rem_q) - 32'(ENCODER_COUNTS)) : rem_q;
		p_fold = (32'(r_mod) * 32'd2 > 32'(ENCODER_COUNTS))
			? ENC_W'(32'(ENCODER_COUNTS) - 32'(r_mod)) : r_mod;
		p_ok = (32'(p_fold) * 32'd4) <= 32'(ENCODER_COUNTS);
	end

	always_comb begin
		prod    = (PROD_W'(pp_hi_q) << LO_W) + PROD_W'(pp_lo_q);
		prod_sh = SHX_W'(prod >> COS_FRAC_BITS);
	end

	assign depth_new = in_range_q ? depth_calc_q : held_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lpc_q      <= LPC_RESET;
			thr_q      <= THR_RESET;
			phase_q    <= PH_IDLE;
			cw_q       <= '0;
			ccw_q      <= '0;
			total_q    <= '0;
			held_q     <= '0;
			in_range_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_LINE_PER_COUNT:  lpc_q <= cfg_data[LPC_W-1:0];
					CFG_DRIVE_THRESHOLD: thr_q <= cfg_data[THR_W-1:0];
					default: ;
				endcase
			end
			if (cmd.load) begin
				phase_q <= phase_nxt;
				if (inc_cw) begin
					cw_q <= cw_q + 1'b1;
				end
				if (inc_ccw) begin
					ccw_q <= ccw_q + 1'b1;
				end
				if (inc_cw || inc_ccw) begin
					total_q <= total_q + 1'b1;
				end
			end
			if (cmd.fold) begin
				in_range_q <= p_ok;
			end
			if (cmd.finish) begin
				held_q <= depth_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			enc_q   <= encoder_count;
			q_est_q <= QEST_W'((32'(encoder_count) * RECIP) >> MOD_SHIFT);
		end
		if (cmd.modulo) begin
			rem_q <= enc_q - ENC_W'(32'(q_est_q) * 32'(ENCODER_COUNTS));
			mag_q <= net[COUNT_WIDTH-1] ? (~net + 1'b1) : net;
		end
		if (cmd.fold) begin
			p_q    <= p_fold;
			line_q <= LINE_W'(mag_q) * LINE_W'(lpc_q);
		end
		if (cmd.rom && in_range_q) begin
			cos_q <= cos_rom[p_q[IDX_W-1:0]];
		end
		if (cmd.mult) begin
			pp_lo_q <= PP_LO_W'(line_q[LO_W-1:0]) * PP_LO_W'(cos_q);
			pp_hi_q <= PP_HI_W'(line_q[LINE_W-1:LO_W]) * PP_HI_W'(cos_q);
		end
		if (cmd.sum) begin
			depth_calc_q <= ((prod_sh >> DEPTH_W) != '0) ? '1 : prod_sh[DEPTH_W-1:0];
		end
		if (cmd.finish) begin
			cw_passes  <= OUT_CNT_W'(cw_q);
			ccw_passes <= OUT_CNT_W'(ccw_q);
			all_passes <= OUT_CNT_W'(total_q);
			net_passes <= OUT_CNT_W'(signed'(net));
			depth_q16  <= depth_new;
			drive_on   <= depth_new[DEPTH_W-1:16] > 32'(thr_q);
		end
	end

	assign status.in_range = in_range_q;

	`ASSERT_HOLDS(a_total_is_sum, clk, arst_n, total_q == COUNT_WIDTH'(cw_q + ccw_q))
	`ASSERT_NEXT(a_held_only_on_finish, clk, arst_n, !cmd.finish, $stable(held_q))

endmodule

`default_nettype wire

// ===== src/hall_line_counter_depth.sv =====
// Sequence: an item whose folded angle is at most ninety degrees steps from acceptance through
// MOD, FOLD, ROM, MULT, SUM and DONE; above ninety degrees, ROM goes straight to DONE.
// Throughput: a new item is taken only in IDLE, once the sequencer has finished stepping the last
// one, and DONE waits while the output register still holds an unread result.
// Reset (arst_n low, asynchronous): counters, pass phase and held depth clear, the registers
// return to 9858 and 10, and no result is pending.
`default_nettype none

module hall_line_counter_depth import hlcd_pkg::*; #(
	parameter int ENCODER_COUNTS = 2048,
	parameter int COUNT_WIDTH    = 32,
	parameter int COS_FRAC_BITS  = 16
) (
	input wire logic     clk,
	input wire logic     arst_n,
	hlcd_hall_if.sink    hall,
	hlcd_result_if.source result,
	hlcd_cfg_if.sink     cfg
);

	// The block is a small sequencer (hlcd_ctrl) that steps a datapath (hlcd_datapath).
	// An accepted transaction updates the pass state machine and the three counters in the
	// same edge, and starts the depth computation:
	//   MOD  - remainder of the encoder count from a reciprocal quotient estimate, and the
	//          magnitude of the net pass count.
	//   FOLD - final remainder correction, fold onto 0..180 degrees, range check, and the
	//          line length product.
	//   ROM  - registered read of the cosine table; out-of-range items go straight to DONE.
	//   MULT - two partial products of line length and cosine.
	//   SUM  - recombination, Q shift and saturation to 48 bits.
	//   DONE - the result lands in the output register once it is free.
	// A finished result may sit in the output register while the next transaction is taken,
	// so the sink can stall without blocking the input side until a second result is ready.

	dp_cmd_t    cmd;
	dp_status_t status;

	hlcd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (hall.valid),
		.in_ready  (hall.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Register writes are always taken; the user, not the block, keeps them to idle time.
	assign cfg.ready = 1'b1;

	hlcd_datapath #(
		.ENCODER_COUNTS (ENCODER_COUNTS),
		.COUNT_WIDTH    (COUNT_WIDTH),
		.COS_FRAC_BITS  (COS_FRAC_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.kind          (hall.kind),
		.hall_a        (hall.hall_a),
		.hall_b        (hall.hall_b),
		.encoder_count (hall.encoder_count),
		.cfg_we        (cfg.valid),
		.cfg_index     (cfg.index),
		.cfg_data      (cfg.data),
		.cw_passes     (result.cw_passes),
		.ccw_passes    (result.ccw_passes),
		.all_passes    (result.all_passes),
		.net_passes    (result.net_passes),
		.depth_q16     (result.depth_q16),
		.drive_on      (result.drive_on)
	);

endmodule

`default_nettype wire
